[src/rrsr_pkg.sv]
package rrsr_pkg;

  // Field and register widths
  localparam int BYTE_W       = 8;
  localparam int GROUP_BYTES  = 6;
  localparam int GROUP_W      = GROUP_BYTES * BYTE_W;
  localparam int POS_W        = 3;
  localparam int MODE_W       = 1;
  localparam int GPL_W        = 12;
  localparam int PAD_W        = 10;
  localparam int LPF_W        = 15;
  localparam int LINE_CNT_W   = LPF_W - 1;
  localparam int CFG_ADDR_W   = 2;
  localparam int CFG_DATA_W   = 15;
  localparam int OUT_USER_W   = 2;

  // Line length limit and frame height limit
  localparam int MAX_LINE_GROUPS = 2048;
  localparam int MAX_FRAME_LINES = 16384;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_PIXEL_MODE      = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_GROUPS_PER_LINE = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_PAD_BYTES       = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_LINES_PER_FRAME = 2'd3;

  // Pixel modes
  localparam logic MODE_RAW10 = 1'b0;
  localparam logic MODE_RAW12 = 1'b1;

  // Last byte position of a group, per mode
  localparam logic [POS_W-1:0] LAST_POS_RAW10 = 3'd4;
  localparam logic [POS_W-1:0] LAST_POS_RAW12 = 3'd5;

  typedef logic [GROUP_BYTES-1:0][BYTE_W-1:0] grp_bytes_t;

  typedef struct packed {
    logic             pixel_mode;
    logic [GPL_W-1:0] groups_per_line;
    logic [PAD_W-1:0] pad_bytes;
    logic [LPF_W-1:0] lines_per_frame;
  } cfg_t;

  // One finished group handed to the output stage
  typedef struct packed {
    logic               load;
    logic               raw12;
    logic               eol;
    logic               eof;
    logic [GROUP_W-1:0] data;
  } grp_res_t;

  // Ten-bit group: four high bytes, then the low bits; result MSB first
  function automatic logic [GROUP_W-1:0] pack10(input grp_bytes_t g);
    logic [BYTE_W-1:0] lo;
    lo = g[4];
    pack10 = {g[0], lo[7:6], g[1], lo[5:4], g[2], lo[3:2], g[3], lo[1:0],
              8'h00};
  endfunction

  // Twelve-bit group: two pixel pairs, each with a shared low-nibble byte
  function automatic logic [GROUP_W-1:0] pack12(input grp_bytes_t g);
    pack12 = {g[0], g[2][7:4], g[1], g[2][3:0],
              g[3], g[5][7:4], g[4], g[5][3:0]};
  endfunction

endpackage

[src/rrsr_collect.sv]
module rrsr_collect #(
  parameter int MAX_LINE_GROUPS = rrsr_pkg::MAX_LINE_GROUPS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  rrsr_pkg::cfg_t                    cfg,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [rrsr_pkg::BYTE_W-1:0]       in_tdata,
  input  logic                              can_load,
  output rrsr_pkg::grp_res_t                res
);

  localparam int GW = $clog2(MAX_LINE_GROUPS + 1);
  localparam int LW = (GW > rrsr_pkg::GPL_W) ? GW : rrsr_pkg::GPL_W;
  localparam int FW = rrsr_pkg::LPF_W;

  rrsr_pkg::grp_bytes_t                 store_r, store_nxt;
  logic [rrsr_pkg::POS_W-1:0]           pos_r, pos_nxt;
  logic [GW-1:0]                        grp_cnt_r, grp_cnt_nxt;
  logic [rrsr_pkg::LINE_CNT_W-1:0]      line_cnt_r, line_cnt_nxt;
  logic [rrsr_pkg::PAD_W-1:0]           pad_r, pad_nxt;

  logic [rrsr_pkg::POS_W-1:0] last_pos;
  logic [rrsr_pkg::POS_W-1:0] wr_idx;
  logic                       completes;
  logic                       accept;
  rrsr_pkg::grp_bytes_t       grp;
  logic [LW-1:0]              line_len;
  logic [LW-1:0]              grp_cnt_inc;
  logic [FW-1:0]              frame_len;
  logic [FW-1:0]              line_cnt_inc;
  logic                       eol;
  logic                       eof;

  // Group size and completion depend on state only
  assign last_pos  = cfg.pixel_mode ? rrsr_pkg::LAST_POS_RAW12 : rrsr_pkg::LAST_POS_RAW10;
  assign completes = (pad_r == '0) && (pos_r >= last_pos);
  assign in_tready = !completes || can_load;
  assign accept    = in_tvalid && in_tready;

  // Store slot for the incoming byte, wrapped to the store depth
  assign wr_idx = (pos_r >= rrsr_pkg::POS_W'(rrsr_pkg::GROUP_BYTES))
                ? pos_r - rrsr_pkg::POS_W'(rrsr_pkg::GROUP_BYTES) : pos_r;

  // Group as seen with the incoming byte merged in
  always_comb begin
    grp = store_r;
    grp[wr_idx] = in_tdata;
  end

  // Clamp line length and frame height
  always_comb begin
    line_len = LW'(cfg.groups_per_line);
    if (line_len == '0) begin
      line_len = LW'(1);
    end else if (line_len > LW'(MAX_LINE_GROUPS)) begin
      line_len = LW'(MAX_LINE_GROUPS);
    end
    frame_len = cfg.lines_per_frame;
    if (frame_len == '0) begin
      frame_len = FW'(1);
    end else if (frame_len > FW'(rrsr_pkg::MAX_FRAME_LINES)) begin
      frame_len = FW'(rrsr_pkg::MAX_FRAME_LINES);
    end
  end

  assign grp_cnt_inc  = LW'(grp_cnt_r) + LW'(1);
  assign line_cnt_inc = FW'(line_cnt_r) + FW'(1);
  assign eol = grp_cnt_inc >= line_len;
  assign eof = eol && (line_cnt_inc >= frame_len);

  // Hand a finished group to the output stage
  always_comb begin
    res.load  = accept && completes;
    res.raw12 = cfg.pixel_mode;
    res.eol   = eol;
    res.eof   = eof;
    res.data  = cfg.pixel_mode ? rrsr_pkg::pack12(grp) : rrsr_pkg::pack10(grp);
  end

  // Drop padding, collect bytes, advance line and frame counters
  always_comb begin
    store_nxt    = store_r;
    pos_nxt      = pos_r;
    grp_cnt_nxt  = grp_cnt_r;
    line_cnt_nxt = line_cnt_r;
    pad_nxt      = pad_r;
    if (accept) begin
      if (pad_r != '0) begin
        pad_nxt = pad_r - rrsr_pkg::PAD_W'(1);
      end else begin
        store_nxt = grp;
        if (completes) begin
          pos_nxt = '0;
          if (eol) begin
            grp_cnt_nxt = '0;
            pad_nxt     = cfg.pad_bytes;
            if (eof) begin
              line_cnt_nxt = '0;
            end else begin
              line_cnt_nxt = rrsr_pkg::LINE_CNT_W'(line_cnt_inc);
            end
          end else begin
            grp_cnt_nxt = GW'(grp_cnt_inc);
          end
        end else begin
          pos_nxt = pos_r + rrsr_pkg::POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      grp_cnt_r  <= '0;
      line_cnt_r <= '0;
      pad_r      <= '0;
    end else begin
      pos_r      <= pos_nxt;
      grp_cnt_r  <= grp_cnt_nxt;
      line_cnt_r <= line_cnt_nxt;
      pad_r      <= pad_nxt;
    end
  end

  // Group bytes hold payload only
  always_ff @(posedge clk) begin
    store_r <= store_nxt;
  end

endmodule

[src/rrsr_outbuf.sv]
module rrsr_outbuf (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rrsr_pkg::grp_res_t                  res,
  output logic                                can_load,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [rrsr_pkg::BYTE_W-1:0]         out_tdata,
  output logic                                out_tlast,
  output logic [rrsr_pkg::OUT_USER_W-1:0]     out_tuser
);

  logic [rrsr_pkg::GROUP_W-1:0] data_r, data_nxt;
  logic [rrsr_pkg::POS_W-1:0]   cnt_r, cnt_nxt;
  logic                         eol_r, eol_nxt;
  logic                         eof_r, eof_nxt;
  logic                         take;
  logic                         last;

  assign out_tvalid = (cnt_r != '0);
  assign take       = out_tvalid && out_tready;
  assign last       = (cnt_r == rrsr_pkg::POS_W'(1));
  assign can_load   = (cnt_r == '0) || (last && out_tready);

  assign out_tdata  = data_r[rrsr_pkg::GROUP_W-1 -: rrsr_pkg::BYTE_W];
  assign out_tlast  = last;
  assign out_tuser  = {last && eof_r, last && eol_r};

  // Shift out one byte per beat, reload when the last beat leaves
  always_comb begin
    data_nxt = data_r;
    cnt_nxt  = cnt_r;
    eol_nxt  = eol_r;
    eof_nxt  = eof_r;
    if (take) begin
      data_nxt = data_r << rrsr_pkg::BYTE_W;
      cnt_nxt  = cnt_r - rrsr_pkg::POS_W'(1);
    end
    if (res.load) begin
      data_nxt = res.data;
      cnt_nxt  = res.raw12 ? rrsr_pkg::LAST_POS_RAW12 + rrsr_pkg::POS_W'(1)
                           : rrsr_pkg::LAST_POS_RAW10 + rrsr_pkg::POS_W'(1);
      eol_nxt  = res.eol;
      eof_nxt  = res.eof;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    eol_r  <= eol_nxt;
    eof_r  <= eof_nxt;
  end

endmodule

[src/raw10_raw12_sensor_to_sequential_repack.sv]
// Output: the first output beat of a group becomes valid in the cycle after the input
//   beat that completes the group; the group then leaves in 5 or 6 beats.
// Throughput: one source byte per cycle while in_tready is high, one output byte per
//   cycle while out_tready is high; padding bytes are taken one per cycle and produce nothing.
// Reset (rst_n low, synchronous): registers return to defaults, counters clear,
//   the output stage empties.
module raw10_raw12_sensor_to_sequential_repack #(
  parameter int MAX_LINE_GROUPS = rrsr_pkg::MAX_LINE_GROUPS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // source_byte
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [rrsr_pkg::BYTE_W-1:0]         in_tdata,
  // out_byte; tlast is last_of_group
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [rrsr_pkg::BYTE_W-1:0]         out_tdata,
  output logic                                out_tlast,
  // bit 0 end_of_line, bit 1 end_of_frame
  output logic [rrsr_pkg::OUT_USER_W-1:0]     out_tuser,
  input  logic                                cfg_we,
  input  logic [rrsr_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [rrsr_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  rrsr_pkg::cfg_t     cfg_r;
  rrsr_pkg::grp_res_t res;
  logic               can_load;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pixel_mode      <= rrsr_pkg::MODE_RAW10;
      cfg_r.groups_per_line <= rrsr_pkg::GPL_W'(1);
      cfg_r.pad_bytes       <= '0;
      cfg_r.lines_per_frame <= rrsr_pkg::LPF_W'(1);
    end else if (cfg_we) begin
      case (cfg_addr)
        rrsr_pkg::REG_PIXEL_MODE:      cfg_r.pixel_mode <= cfg_wdata[0];
        rrsr_pkg::REG_GROUPS_PER_LINE: cfg_r.groups_per_line <= cfg_wdata[rrsr_pkg::GPL_W-1:0];
        rrsr_pkg::REG_PAD_BYTES:       cfg_r.pad_bytes <= cfg_wdata[rrsr_pkg::PAD_W-1:0];
        rrsr_pkg::REG_LINES_PER_FRAME: cfg_r.lines_per_frame <= cfg_wdata[rrsr_pkg::LPF_W-1:0];
        default: begin
        end
      endcase
    end
  end

  rrsr_collect #(
    .MAX_LINE_GROUPS(MAX_LINE_GROUPS)
  ) u_collect (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .can_load  (can_load),
    .res       (res)
  );

  rrsr_outbuf u_outbuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .res        (res),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

[src/rrsr_check.sv]
module rrsr_check (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_tready,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [rrsr_pkg::BYTE_W-1:0]         out_tdata,
  input logic                                out_tlast,
  input logic [rrsr_pkg::OUT_USER_W-1:0]     out_tuser
);

  // Output is empty right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // Stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output beat changed");

  // Input stalls only while output is occupied
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with empty output");

  // Line and frame ends fall on the last byte of a group
  a_end_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != '0) |-> out_tlast)
    else $error("line or frame end off group end");

  // Frame end is also a line end
  a_eof_eol: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tuser[0])
    else $error("frame end without line end");

endmodule

bind raw10_raw12_sensor_to_sequential_repack rrsr_check u_rrsr_check (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
